/* hdl/bem_pkg.sv */
// Package for the band energy frame meter: widths, register reset values,
// register indexes, multiplier operation codes and controller/datapath structs.
// No dependencies.
package bem_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int COEF_W            = 16;
    localparam int LEN_W             = 12;
    localparam int FILT_W            = 24;
    localparam int SUM_W             = 48;
    localparam int RMS_W             = 16;
    localparam int NUM_CH            = 5;
    localparam int CH_W              = 3;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int DEF_MAX_FRAME_LEN = 4096;

    localparam logic [COEF_W-1:0] LOW_COEF_RST  = 16'd1274;
    localparam logic [COEF_W-1:0] MID_COEF_RST  = 16'd15095;
    localparam logic [COEF_W-1:0] HIGH_COEF_RST = 16'd38824;
    localparam logic [LEN_W-1:0]  FRAME_LEN_RST = 12'd800;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOW_COEF  = 3'd0,
        REG_MID_COEF  = 3'd1,
        REG_HIGH_COEF = 3'd2,
        REG_FRAME_LEN = 3'd3
    } cfg_reg_t;

    // channel order of the energy sums: low, mid, high, left, right
    localparam logic [CH_W-1:0] CH_LOW   = 3'd0;
    localparam logic [CH_W-1:0] CH_MID   = 3'd1;
    localparam logic [CH_W-1:0] CH_HIGH  = 3'd2;
    localparam logic [CH_W-1:0] CH_LEFT  = 3'd3;
    localparam logic [CH_W-1:0] CH_RIGHT = 3'd4;

    typedef enum logic [2:0] {
        OP_LOW,
        OP_MID,
        OP_HIGH,
        OP_SQ_LOW,
        OP_SQ_MID,
        OP_SQ_HIGH,
        OP_SQ_LEFT,
        OP_SQ_RIGHT
    } mac_op_t;

    typedef struct packed {
        logic            load_sample;
        logic            mac_mul;
        logic            mac_wb;
        mac_op_t         op;
        logic            count_inc;
        logic            count_clear;
        logic            ds_start;
        logic            res_store;
        logic            out_load;
        logic [CH_W-1:0] ch;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic ds_done;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/bem_sample_if.sv */
// Input channel: one stereo sample pair per transaction.
// Depends on bem_pkg.
interface bem_sample_if;
    import bem_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* hdl/bem_result_if.sv */
// Output channel: five RMS levels per transaction, one per frame.
// Depends on bem_pkg.
interface bem_result_if;
    import bem_pkg::*;

    logic             valid;
    logic             ready;
    logic [RMS_W-1:0] low_rms;
    logic [RMS_W-1:0] mid_rms;
    logic [RMS_W-1:0] high_rms;
    logic [RMS_W-1:0] left_rms;
    logic [RMS_W-1:0] right_rms;

    modport source (output valid, output low_rms, output mid_rms, output high_rms,
                    output left_rms, output right_rms, input ready);
    modport sink   (input valid, input low_rms, input mid_rms, input high_rms,
                    input left_rms, input right_rms, output ready);
endinterface

/* hdl/bem_cfg_if.sv */
// Configuration write channel: register index and write data per transaction.
// Depends on bem_pkg.
interface bem_cfg_if;
    import bem_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/bem_divsqrt.sv */
// Iterative unit: restoring divide of a 48-bit sum by the sample count, one
// quotient bit per cycle, then a bit-pair integer square root, saturated to 16 bits.
// Depends on bem_pkg.
module bem_divsqrt #(
    parameter int DIV_W = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bem_pkg::SUM_W-1:0]   dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic [bem_pkg::RMS_W-1:0]   root
);
    import bem_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT
    } ds_state_t;

    ds_state_t           state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                done_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    dvs_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    r_reg;
    logic [SUM_W-1:0]    bit_reg;

    logic [DIV_W:0]      trial;
    logic                trial_ge;
    logic [DIV_W:0]      trial_sub;
    logic [SUM_W:0]      sq_t;
    logic                sq_ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge  = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};
        sq_t      = {1'b0, r_reg} + {1'b0, bit_reg};
        sq_ge     = {1'b0, quo_reg} >= sq_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DS_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= DS_DIV;
                        step_reg  <= '0;
                    end
                end
                DS_DIV:
                begin
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        state_reg <= DS_SQRT;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                DS_SQRT:
                begin
                    if (step_reg == STEP_W'(SUM_W / 2 - 1))
                    begin
                        state_reg <= DS_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= DS_IDLE;
                end
            endcase
        end
    end

    // root holds in idle until the next start
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    rem_reg <= '0;
                    dvs_reg <= divisor;
                    quo_reg <= dividend;
                    r_reg   <= '0;
                    bit_reg <= SUM_W'(1) << (SUM_W - 2);
                end
            end
            DS_DIV:
            begin
                if (trial_ge)
                begin
                    rem_reg <= trial_sub[DIV_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[DIV_W-1:0];
                end
                quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            end
            DS_SQRT:
            begin
                if (sq_ge)
                begin
                    quo_reg <= quo_reg - sq_t[SUM_W-1:0];
                    r_reg   <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign root = (r_reg[SUM_W-1:RMS_W] != '0) ? '1 : r_reg[RMS_W-1:0];

endmodule

/* hdl/bem_datapath.sv */
// Datapath: configuration registers, band filters on one shared multiplier,
// energy sums, sample count, divide/root unit and the output register.
// Depends on bem_pkg and bem_divsqrt.
module bem_datapath #(
    parameter int MAX_FRAME_LEN = bem_pkg::DEF_MAX_FRAME_LEN
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bem_pkg::dp_cmd_t                   cmd,
    output bem_pkg::dp_status_t                status,
    input  logic signed [bem_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [bem_pkg::SAMPLE_W-1:0] right_sample,
    input  logic                               cfg_we,
    input  logic [bem_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [bem_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bem_pkg::RMS_W-1:0]          low_rms,
    output logic [bem_pkg::RMS_W-1:0]          mid_rms,
    output logic [bem_pkg::RMS_W-1:0]          high_rms,
    output logic [bem_pkg::RMS_W-1:0]          left_rms,
    output logic [bem_pkg::RMS_W-1:0]          right_rms
);
    import bem_pkg::*;

    localparam int CNT_W = (MAX_FRAME_LEN > 2) ? $clog2(MAX_FRAME_LEN) : 1;
    localparam int N_W   = CNT_W + 1;
    localparam int CMP_W = (N_W > LEN_W) ? N_W : LEN_W;

    function automatic logic signed [FILT_W-1:0] sat24(input logic signed [29:0] v);
        logic signed [FILT_W-1:0] r;
        if (v > 30'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -30'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[FILT_W-1:0];
        end
        return r;
    endfunction

    logic [COEF_W-1:0]          low_coef_reg;
    logic [COEF_W-1:0]          mid_coef_reg;
    logic [COEF_W-1:0]          high_coef_reg;
    logic [LEN_W-1:0]           frame_len_reg;

    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] prev_mono_reg;
    logic signed [FILT_W-1:0]   low_filter_reg;
    logic signed [FILT_W-1:0]   mid_filter_reg;
    logic signed [FILT_W-1:0]   high_filter_reg;
    logic signed [44:0]         prod_reg;
    logic [SUM_W-1:0]           sum_reg [NUM_CH];
    logic [CNT_W-1:0]           count_reg;
    logic [RMS_W-1:0]           res_reg [NUM_CH];
    logic [RMS_W-1:0]           out_rms_reg [NUM_CH];
    logic                       out_valid_reg;

    logic signed [SAMPLE_W:0]   lr_sum;
    logic signed [24:0]         x_scaled;
    logic signed [24:0]         low_d;
    logic signed [24:0]         mid_d;
    logic signed [SAMPLE_W:0]   hp_diff;
    logic signed [25:0]         hp_t;
    logic signed [24:0]         band_diff;
    logic signed [16:0]         mid_band;
    logic signed [15:0]         low_band;
    logic signed [15:0]         high_band;
    logic signed [26:0]         mul_a;
    logic signed [17:0]         mul_b;
    logic signed [44:0]         prod_next;
    logic signed [28:0]         prod_shr;
    logic signed [FILT_W-1:0]   low_next;
    logic signed [FILT_W-1:0]   mid_next;
    logic signed [FILT_W-1:0]   high_next;
    logic [CH_W-1:0]            sq_sel;
    logic [CH_W-1:0]            sum_addr;
    logic [SUM_W:0]             sum_acc;
    logic [SUM_W-1:0]           sum_sat;
    logic [N_W-1:0]             n_val;
    logic [CMP_W-1:0]           len_raw;
    logic [CMP_W-1:0]           len_eff;
    logic                       ds_done;
    logic [RMS_W-1:0]           ds_root;

    always_comb
    begin
        lr_sum    = {left_sample[SAMPLE_W-1], left_sample}
                  + {right_sample[SAMPLE_W-1], right_sample};
        x_scaled  = {x_reg[SAMPLE_W-1], x_reg, 8'h00};
        low_d     = x_scaled - 25'(low_filter_reg);
        mid_d     = x_scaled - 25'(mid_filter_reg);
        hp_diff   = {x_reg[SAMPLE_W-1], x_reg} - {prev_mono_reg[SAMPLE_W-1], prev_mono_reg};
        hp_t      = 26'(high_filter_reg) + 26'($signed({hp_diff, 8'h00}));
        band_diff = 25'(mid_filter_reg) - 25'(low_filter_reg);
        mid_band  = $signed(band_diff[24:8]);
        low_band  = $signed(low_filter_reg[23:8]);
        high_band = $signed(high_filter_reg[23:8]);

        mul_a  = '0;
        mul_b  = '0;
        sq_sel = CH_LOW;
        unique case (cmd.op)
            OP_LOW:
            begin
                mul_a = 27'(low_d);
                mul_b = $signed({2'b00, low_coef_reg});
            end
            OP_MID:
            begin
                mul_a = 27'(mid_d);
                mul_b = $signed({2'b00, mid_coef_reg});
            end
            OP_HIGH:
            begin
                mul_a = 27'(hp_t);
                mul_b = $signed({2'b00, high_coef_reg});
            end
            OP_SQ_LOW:
            begin
                mul_a  = 27'(low_band);
                mul_b  = 18'(low_band);
                sq_sel = CH_LOW;
            end
            OP_SQ_MID:
            begin
                mul_a  = 27'(mid_band);
                mul_b  = 18'(mid_band);
                sq_sel = CH_MID;
            end
            OP_SQ_HIGH:
            begin
                mul_a  = 27'(high_band);
                mul_b  = 18'(high_band);
                sq_sel = CH_HIGH;
            end
            OP_SQ_LEFT:
            begin
                mul_a  = 27'(left_reg);
                mul_b  = 18'(left_reg);
                sq_sel = CH_LEFT;
            end
            OP_SQ_RIGHT:
            begin
                mul_a  = 27'(right_reg);
                mul_b  = 18'(right_reg);
                sq_sel = CH_RIGHT;
            end
        endcase

        prod_next = mul_a * mul_b;
        prod_shr  = $signed(prod_reg[44:16]);
        low_next  = sat24(30'(low_filter_reg) + 30'(prod_shr));
        mid_next  = sat24(30'(mid_filter_reg) + 30'(prod_shr));
        high_next = sat24(30'(prod_shr));

        sum_addr = cmd.mac_wb ? sq_sel : cmd.ch;
        sum_acc  = {1'b0, sum_reg[sum_addr]} + (SUM_W + 1)'(prod_reg[33:0]);
        sum_sat  = sum_acc[SUM_W] ? '1 : sum_acc[SUM_W-1:0];

        n_val   = {1'b0, count_reg} + N_W'(1);
        len_raw = CMP_W'(frame_len_reg);
        if (len_raw == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (len_raw > CMP_W'(MAX_FRAME_LEN))
        begin
            len_eff = CMP_W'(MAX_FRAME_LEN);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_coef_reg    <= LOW_COEF_RST;
            mid_coef_reg    <= MID_COEF_RST;
            high_coef_reg   <= HIGH_COEF_RST;
            frame_len_reg   <= FRAME_LEN_RST;
            low_filter_reg  <= '0;
            mid_filter_reg  <= '0;
            high_filter_reg <= '0;
            prev_mono_reg   <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOW_COEF:  low_coef_reg  <= cfg_data[COEF_W-1:0];
                    REG_MID_COEF:  mid_coef_reg  <= cfg_data[COEF_W-1:0];
                    REG_HIGH_COEF: high_coef_reg <= cfg_data[COEF_W-1:0];
                    REG_FRAME_LEN: frame_len_reg <= cfg_data[LEN_W-1:0];
                    default:       low_coef_reg  <= low_coef_reg;
                endcase
            end

            if (cmd.mac_wb)
            begin
                unique case (cmd.op)
                    OP_LOW:  low_filter_reg <= low_next;
                    OP_MID:  mid_filter_reg <= mid_next;
                    OP_HIGH:
                    begin
                        high_filter_reg <= high_next;
                        prev_mono_reg   <= x_reg;
                    end
                    OP_SQ_LOW, OP_SQ_MID, OP_SQ_HIGH, OP_SQ_LEFT, OP_SQ_RIGHT:
                    begin
                        sum_reg[sum_addr] <= sum_sat;
                    end
                endcase
            end

            if (cmd.res_store)
            begin
                sum_reg[sum_addr] <= '0;
            end

            priority if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= n_val[CNT_W-1:0];
            end

            priority if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
            x_reg     <= lr_sum[SAMPLE_W:1];
        end
        if (cmd.mac_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.res_store)
        begin
            res_reg[cmd.ch] <= ds_root;
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                out_rms_reg[i] <= res_reg[i];
            end
        end
    end

    bem_divsqrt #(
        .DIV_W (N_W)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.ds_start),
        .dividend (sum_reg[sum_addr]),
        .divisor  (n_val),
        .done     (ds_done),
        .root     (ds_root)
    );

    assign status.frame_end = CMP_W'(n_val) >= len_eff;
    assign status.ds_done   = ds_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign low_rms   = out_rms_reg[CH_LOW];
    assign mid_rms   = out_rms_reg[CH_MID];
    assign high_rms  = out_rms_reg[CH_HIGH];
    assign left_rms  = out_rms_reg[CH_LEFT];
    assign right_rms = out_rms_reg[CH_RIGHT];

endmodule

/* hdl/bem_ctrl.sv */
// Controller: sequences the eight multiplier operations per sample, the frame
// check, the five divide/root passes and the output load.
// Depends on bem_pkg.
module bem_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bem_pkg::dp_status_t status,
    output bem_pkg::dp_cmd_t    cmd
);
    import bem_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_CHECK,
        ST_DS_START,
        ST_DS_WAIT,
        ST_DS_STORE,
        ST_OUT_WAIT
    } state_t;

    state_t          state_reg;
    mac_op_t         op_reg;
    logic [CH_W-1:0] ch_reg;
    logic            accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.op          = op_reg;
        cmd.ch          = ch_reg;
        cmd.load_sample = accept;
        unique case (state_reg)
            ST_IDLE:     cmd.load_sample = accept;
            ST_MUL:      cmd.mac_mul     = 1'b1;
            ST_WB:       cmd.mac_wb      = 1'b1;
            ST_CHECK:    cmd.count_inc   = !status.frame_end;
            ST_DS_START: cmd.ds_start    = 1'b1;
            ST_DS_WAIT:  cmd.ds_start    = 1'b0;
            ST_DS_STORE: cmd.res_store   = 1'b1;
            ST_OUT_WAIT:
            begin
                cmd.out_load    = status.out_free;
                cmd.count_clear = status.out_free;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_LOW;
            ch_reg    <= CH_LOW;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_MUL;
                        op_reg    <= OP_LOW;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    if (op_reg == OP_SQ_RIGHT)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        op_reg    <= mac_op_t'(3'(op_reg) + 3'd1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_CHECK:
                begin
                    if (status.frame_end)
                    begin
                        state_reg <= ST_DS_START;
                        ch_reg    <= CH_LOW;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DS_START:
                begin
                    state_reg <= ST_DS_WAIT;
                end
                ST_DS_WAIT:
                begin
                    if (status.ds_done)
                    begin
                        state_reg <= ST_DS_STORE;
                    end
                end
                ST_DS_STORE:
                begin
                    if (ch_reg == CH_W'(NUM_CH - 1))
                    begin
                        state_reg <= ST_OUT_WAIT;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + CH_W'(1);
                        state_reg <= ST_DS_START;
                    end
                end
                ST_OUT_WAIT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

/* hdl/band_energy_frame_meter.sv */
// Three band RMS level meter, top level. A sample transaction is accepted only in
// idle; each is then handled as an accept, eight operations (multiply, then write
// back) on the shared 27x18 multiplier and a frame check, before another is taken.
// On the last sample of a frame, five divide/root passes (restoring divide, then
// root) follow before the result loads into the output register once it is free.
// Reset (rst_n, asynchronous, active low) clears filters, sums, count and the output valid flag.
module band_energy_frame_meter #(
    parameter int MAX_FRAME_LEN = bem_pkg::DEF_MAX_FRAME_LEN
) (
    input  logic          clk,
    input  logic          rst_n,
    bem_sample_if.sink    sample,
    bem_result_if.source  result,
    bem_cfg_if.sink       cfg
);
    import bem_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    bem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bem_datapath #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .left_sample  (sample.left_sample),
        .right_sample (sample.right_sample),
        .cfg_we       (cfg.valid && cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .low_rms      (result.low_rms),
        .mid_rms      (result.mid_rms),
        .high_rms     (result.high_rms),
        .left_rms     (result.left_rms),
        .right_rms    (result.right_rms)
    );

endmodule

/* dv/band_energy_frame_meter_tb.sv */
// Self-checking testbench for band_energy_frame_meter: directed table, then random phases.
// Results are checked against an in-bench three band filter and frame RMS predictor.
// Depends on bem_pkg and the bem_sample_if, bem_result_if and bem_cfg_if interfaces.
module band_energy_frame_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bem_pkg::*;

    localparam int          LIMIT_CYCLES = 4_000_000;
    localparam int          SETTLE       = 40;
    localparam int          END_DRAIN    = 500;
    localparam int          NUM_PHASES   = 14;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          HOLD_PHASE   = 3;
    localparam int          HOLD_AT      = 10;
    localparam int          HOLD_CYCLES  = 3000;
    localparam longint unsigned ENERGY_MAX = (64'd1 << SUM_W) - 64'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [RMS_W-1:0] low;
        logic [RMS_W-1:0] mid;
        logic [RMS_W-1:0] high;
        logic [RMS_W-1:0] left;
        logic [RMS_W-1:0] right;
    } levels_t;

    typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    typedef enum {PAT_NOISE, PAT_FULL_SCALE, PAT_SQUARE, PAT_QUIET, PAT_DC} pattern_t;

    typedef struct {
        row_kind_t                  kind;
        logic [CFG_ADDR_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        bit                         typed;
        levels_t                    want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bem_sample_if sample_ch ();
    bem_result_if result_ch ();
    bem_cfg_if    cfg_ch ();

    band_energy_frame_meter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor copy of configuration and state
    logic [COEF_W-1:0]          coef_low;
    logic [COEF_W-1:0]          coef_mid;
    logic [COEF_W-1:0]          coef_high;
    logic [LEN_W-1:0]           frame_len_cfg;
    logic signed [FILT_W-1:0]   filt_low;
    logic signed [FILT_W-1:0]   filt_mid;
    logic signed [FILT_W-1:0]   filt_high;
    logic signed [SAMPLE_W-1:0] prev_mono;
    logic [SUM_W-1:0]           energy_sum [NUM_CH];
    logic [LEN_W-1:0]           frame_fill;

    levels_t  levels_due [$];
    dir_row_t dir_rows [$];
    int       errors    = 0;
    int       n_samples = 0;
    int       n_frames  = 0;
    int       n_writes  = 0;
    int       cycle_cnt = 0;
    bit       hold_start = 1'b0;
    string    field_name [NUM_CH] = '{"low_rms", "mid_rms", "high_rms", "left_rms", "right_rms"};

    function automatic longint clamp24(input longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // one sample through the filters and frame sums; returns 1 at frame end
    function automatic bit meter_step(input logic signed [SAMPLE_W-1:0] l,
                                      input logic signed [SAMPLE_W-1:0] r,
                                      output levels_t lv);
        longint           mono;
        longint           lo;
        longint           mi;
        longint           hi;
        longint           t;
        longint           band [NUM_CH];
        longint unsigned  acc;
        longint unsigned  v;
        longint unsigned  root;
        longint unsigned  bitv;
        longint unsigned  n;
        longint unsigned  len;
        logic [RMS_W-1:0] rms [NUM_CH];

        mono = (longint'(l) + longint'(r)) >>> 1;
        lo = clamp24(longint'(filt_low)
                     + ((((mono * 256) - longint'(filt_low)) * longint'(coef_low)) >>> 16));
        mi = clamp24(longint'(filt_mid)
                     + ((((mono * 256) - longint'(filt_mid)) * longint'(coef_mid)) >>> 16));
        t  = longint'(filt_high) + (mono - longint'(prev_mono)) * 256;
        hi = clamp24((t * longint'(coef_high)) >>> 16);
        filt_low  = lo[FILT_W-1:0];
        filt_mid  = mi[FILT_W-1:0];
        filt_high = hi[FILT_W-1:0];
        prev_mono = mono[SAMPLE_W-1:0];

        band[CH_LOW]   = lo >>> 8;
        band[CH_MID]   = (mi - lo) >>> 8;
        band[CH_HIGH]  = hi >>> 8;
        band[CH_LEFT]  = longint'(l);
        band[CH_RIGHT] = longint'(r);
        for (int i = 0; i < NUM_CH; i++)
        begin
            acc = longint'(energy_sum[i]) + longint'(band[i] * band[i]);
            if (acc > ENERGY_MAX)
                acc = ENERGY_MAX;
            energy_sum[i] = acc[SUM_W-1:0];
        end

        len = (frame_len_cfg == 0) ? 64'd1 : longint'(frame_len_cfg);
        if (len > 64'(DEF_MAX_FRAME_LEN))
            len = 64'(DEF_MAX_FRAME_LEN);
        n = longint'(frame_fill) + 64'd1;
        if (n < len)
        begin
            frame_fill = n[LEN_W-1:0];
            return 1'b0;
        end

        for (int i = 0; i < NUM_CH; i++)
        begin
            v = longint'(energy_sum[i]) / n;
            root = 64'd0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            rms[i] = (root > 64'd65535) ? 16'hFFFF : root[RMS_W-1:0];
            energy_sum[i] = '0;
        end
        frame_fill = '0;
        lv = '{rms[CH_LOW], rms[CH_MID], rms[CH_HIGH], rms[CH_LEFT], rms[CH_RIGHT]};
        return 1'b1;
    endfunction

    task automatic add_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        dir_rows.push_back('{ROW_CFG, idx, data, '0, '0, 1'b0, '0});
    endtask

    task automatic add_smp(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r,
                           input bit typed, input levels_t want);
        dir_rows.push_back('{ROW_SAMPLE, '0, '0, l, r, typed, want});
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] l,
                               input logic signed [SAMPLE_W-1:0] r,
                               input bit typed, input levels_t want, input int gap);
        levels_t lv;

        sample_ch.valid        <= 1'b1;
        sample_ch.left_sample  <= l;
        sample_ch.right_sample <= r;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        n_samples++;
        if (meter_step(l, r, lv))
            levels_due.push_back(typed ? want : lv);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle(input int settle);
        sample_ch.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        n_writes++;
        case (idx)
            REG_LOW_COEF:  coef_low      = data;
            REG_MID_COEF:  coef_mid      = data;
            REG_HIGH_COEF: coef_high     = data;
            REG_FRAME_LEN: frame_len_cfg = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // result side: check against the oldest pending frame
    always @(posedge clk)
    begin : result_check
        levels_t                   want;
        levels_t                   got;
        logic [NUM_CH*RMS_W-1:0]   wv;
        logic [NUM_CH*RMS_W-1:0]   gv;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.low_rms, result_ch.mid_rms, result_ch.high_rms,
                    result_ch.left_rms, result_ch.right_rms};
            if (levels_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, actual %p", $time, got);
            end
            else
            begin
                want = levels_due.pop_front();
                n_frames++;
                wv = want;
                gv = got;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (wv[(NUM_CH-1-i)*RMS_W +: RMS_W] !== gv[(NUM_CH-1-i)*RMS_W +: RMS_W])
                    begin
                        errors++;
                        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name[i],
                                 wv[(NUM_CH-1-i)*RMS_W +: RMS_W], gv[(NUM_CH-1-i)*RMS_W +: RMS_W]);
                    end
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold-off on request
    initial
    begin : receiver
        rx_mode_t mode;
        int       span;
        int       hold_left;

        result_ch.ready <= 1'b0;
        mode = RX_OPEN;
        span = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (span == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(16, 200);
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 7) == 0);
                    default:   result_ch.ready <= (span % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        levels_t                    zero_lv;
        pattern_t                   pattern;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        logic signed [SAMPLE_W-1:0] dc_l;
        logic signed [SAMPLE_W-1:0] dc_r;
        logic [CFG_DATA_W-1:0]      len_data;
        bit                         toggle;
        int                         burst_left;
        int                         gap;
        int                         sel;

        rst_n                  <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.left_sample  <= '0;
        sample_ch.right_sample <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= '0;
        cfg_ch.data            <= '0;

        coef_low      = LOW_COEF_RST;
        coef_mid      = MID_COEF_RST;
        coef_high     = HIGH_COEF_RST;
        frame_len_cfg = FRAME_LEN_RST;
        filt_low      = '0;
        filt_mid      = '0;
        filt_high     = '0;
        prev_mono     = '0;
        frame_fill    = '0;
        for (int i = 0; i < NUM_CH; i++)
            energy_sum[i] = '0;
        zero_lv = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        add_cfg(REG_FRAME_LEN, 16'd1);
        add_smp(16'sd0, 16'sd0, 1'b1, zero_lv);
        add_cfg(REG_LOW_COEF, 16'h0000);
        add_cfg(REG_MID_COEF, 16'h0000);
        add_cfg(REG_HIGH_COEF, 16'h0000);
        add_smp(-16'sd32768, -16'sd32768, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd32768, 16'd32768});
        add_smp(16'sd32767, 16'sd32767, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd32767, 16'd32767});
        add_smp(16'sd32767, -16'sd32768, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd32767, 16'd32768});
        add_cfg(REG_LOW_COEF, 16'hFFFF);
        add_cfg(REG_MID_COEF, 16'hFFFF);
        add_cfg(REG_HIGH_COEF, 16'hFFFF);
        add_smp(-16'sd32768, 16'sd32767, 1'b0, zero_lv);
        add_cfg(REG_SPARE_FIRST, 16'hFFFF);
        add_smp(16'sd1, -16'sd1, 1'b0, zero_lv);
        add_cfg(REG_SPARE_LAST, 16'h1234);
        // upper bits dropped: frame length reads as zero, one sample per frame
        add_cfg(REG_FRAME_LEN, 16'hF000);
        add_smp(16'sd12345, -16'sd2345, 1'b0, zero_lv);
        // mid band at full swing: low held high, mid driven to the negative rail
        add_cfg(REG_FRAME_LEN, 16'd8);
        repeat (4) add_smp(16'sd32767, 16'sd32767, 1'b0, zero_lv);
        add_cfg(REG_LOW_COEF, 16'h0000);
        repeat (4) add_smp(-16'sd32768, -16'sd32768, 1'b0, zero_lv);
        // longest frame, then cut short mid-frame
        add_cfg(REG_FRAME_LEN, 16'd4095);
        add_smp(-16'sd32768, 16'sd32767, 1'b0, zero_lv);
        add_smp(16'sd32767, -16'sd32768, 1'b0, zero_lv);
        add_smp(-16'sd1, 16'sd0, 1'b0, zero_lv);
        add_cfg(REG_FRAME_LEN, 16'd2);
        add_smp(16'sd0, -16'sd32768, 1'b0, zero_lv);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle(SETTLE);
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
                send_sample(dir_rows[i].l, dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want,
                            $urandom_range(0, 4));
        end

        // random phases
        burst_left = 0;
        pattern = PAT_NOISE;
        dc_l = '0;
        dc_r = '0;
        toggle = 1'b0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle(SETTLE);
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_LOW_COEF, pick_coef());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_MID_COEF, pick_coef());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_HIGH_COEF, pick_coef());
            sel = $urandom_range(0, 9);
            if (phase == HOLD_PHASE)
                len_data = 16'd1;
            else if (sel < 6)
                len_data = 16'($urandom_range(1, 8));
            else if (sel < 8)
                len_data = 16'($urandom_range(9, 64));
            else if (sel == 8)
                len_data = $urandom_range(0, 1) ? {4'($urandom), 12'h000} : 16'($urandom);
            else
                len_data = 16'h0FFF;
            write_reg(REG_FRAME_LEN, len_data);
            if ($urandom_range(0, 5) == 0)
                write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    pattern = pattern_t'($urandom_range(0, 4));
                    dc_l = 16'($urandom);
                    dc_r = 16'($urandom);
                end
                toggle = ~toggle;
                case (pattern)
                    PAT_FULL_SCALE:
                    begin
                        l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end
                    PAT_SQUARE:
                    begin
                        l = toggle ? dc_l : ~dc_l;
                        r = toggle ? dc_r : ~dc_r;
                    end
                    PAT_QUIET:
                    begin
                        l = 16'($urandom_range(0, 511));
                        r = 16'($urandom_range(0, 511));
                        l = l - 16'sd256;
                        r = r - 16'sd256;
                    end
                    PAT_DC:
                    begin
                        l = dc_l;
                        r = dc_r;
                    end
                    default:
                    begin
                        l = 16'($urandom);
                        r = 16'($urandom);
                    end
                endcase
                burst_left--;
                if (burst_left != 0 || $urandom_range(0, 3) == 0)
                    gap = 0;
                else
                    gap = $urandom_range(1, 40);
                if (phase == HOLD_PHASE && k == HOLD_AT)
                    hold_start = 1'b1;
                send_sample(l, r, 1'b0, zero_lv, gap);
            end
        end

        wait_idle(END_DRAIN);
        $display("Summary: %0d sample transactions, %0d frame results, %0d register writes",
                 n_samples, n_frames, n_writes);
        $display("Covered zero/short/4095 frame lengths, coefficient rails, mid-frame cuts, back-pressure");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/bem_pkg.sv
hdl/bem_sample_if.sv
hdl/bem_result_if.sv
hdl/bem_cfg_if.sv
hdl/bem_divsqrt.sv
hdl/bem_datapath.sv
hdl/bem_ctrl.sv
hdl/band_energy_frame_meter.sv
dv/band_energy_frame_meter_tb.sv
